// ===== rtl/upd_pkg.sv =====
// shared types, character constants and hex helpers for the url percent decoder
package upd_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;

  typedef enum logic [2:0] {
    PEND_NONE = 3'b001,
    PEND_PCT  = 3'b010,
    PEND_HI   = 3'b100
  } pend_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eoc;
  } upd_ent_t;

  typedef struct packed {
    logic [CNT_W-1:0]                 cnt;
    upd_ent_t [MAX_RESULTS-1:0]       ent;
  } upd_list_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             can_load;
  } upd_qstat_t;

  function automatic logic is_hex(input logic [7:0] ch);
    return ((ch >= CH_0) && (ch <= CH_9)) ||
           ((ch >= CH_LA) && (ch <= CH_LF)) ||
           ((ch >= CH_UA) && (ch <= CH_UF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if ((ch >= CH_0) && (ch <= CH_9)) begin
      d = ch - CH_0;
    end else if ((ch >= CH_LA) && (ch <= CH_LF)) begin
      d = ch - CH_LA + 8'd10;
    end else if ((ch >= CH_UA) && (ch <= CH_UF)) begin
      d = ch - CH_UA + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] ch);
    return (ch == CH_PLUS) ? CH_SPACE : ch;
  endfunction

  function automatic upd_ent_t mk_ent(input logic [7:0] ch);
    upd_ent_t e;
    e.data     = ch;
    e.has_byte = 1'b1;
    e.eoc      = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// url percent decoder top level: decode stage feeding the result register
// latency: first result of a beat is valid the cycle after the beat is accepted
// throughput: one beat per cycle while each yields at most one result, out_stall low
// a beat's k results (up to three) stay in the result register until all are taken
// reset (synchronous, rst_n low) clears the escape state, held digit and the results
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_component
);

  upd_list_t  lst;
  upd_qstat_t stat;
  logic       fire;

  assign in_stall = !stat.can_load;
  assign fire     = in_valid && !in_stall;

  upd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .lst     (lst)
  );

  upd_outq u_outq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (fire),
    .lst                  (lst),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_byte             (out_byte),
    .out_has_byte         (out_has_byte),
    .out_end_of_component (out_end_of_component),
    .stat                 (stat)
  );

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.cnt > CNT_W'(1)) |-> in_stall)
    else $error("input accepted while several results still queued");

  a_bare_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> out_end_of_component)
    else $error("bare marker without end of component");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && (stat.cnt > CNT_W'(1))) |=> out_valid)
    else $error("queued results lost");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last) |=> out_valid)
    else $error("last beat produced no result");

endmodule

// ===== rtl/upd_decode.sv =====
// escape state and per-beat decode into a short list of result entries
module upd_decode
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output upd_list_t  lst
);

  pend_t      pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;

  always_comb begin
    logic       hex_b;
    logic       pl_hold;
    logic [7:0] pl_byte;
    logic [7:0] val;
    lst      = '0;
    pend_nxt = pend_r;
    held_nxt = held_r;
    hex_b    = is_hex(in_byte);
    pl_hold  = (in_byte == CH_PERCENT) && !in_last;
    pl_byte  = plain_map(in_byte);
    val      = {hex_val(held_r), hex_val(in_byte)};
    unique case (pend_r)
      PEND_PCT: begin
        if (hex_b && !in_last) begin
          pend_nxt = PEND_HI;
          held_nxt = in_byte;
        end else begin
          lst.ent[0] = mk_ent(CH_PERCENT);
          if (pl_hold) begin
            pend_nxt = PEND_PCT;
            lst.cnt  = CNT_W'(1);
          end else begin
            pend_nxt   = PEND_NONE;
            lst.ent[1] = mk_ent(pl_byte);
            lst.cnt    = CNT_W'(2);
          end
        end
      end
      PEND_HI: begin
        held_nxt = '0;
        pend_nxt = PEND_NONE;
        if (hex_b) begin
          if (val != 8'h00) begin
            lst.ent[0] = mk_ent(val);
            lst.cnt    = CNT_W'(1);
          end
        end else begin
          lst.ent[0] = mk_ent(CH_PERCENT);
          lst.ent[1] = mk_ent(held_r);
          if (pl_hold) begin
            pend_nxt = PEND_PCT;
            lst.cnt  = CNT_W'(2);
          end else begin
            lst.ent[2] = mk_ent(pl_byte);
            lst.cnt    = CNT_W'(3);
          end
        end
      end
      default: begin
        if (pl_hold) begin
          pend_nxt = PEND_PCT;
        end else begin
          pend_nxt   = PEND_NONE;
          lst.ent[0] = mk_ent(pl_byte);
          lst.cnt    = CNT_W'(1);
        end
      end
    endcase
    if (in_last) begin
      pend_nxt = PEND_NONE;
      held_nxt = '0;
      if (lst.cnt == '0) begin
        lst.ent[0] = '0;
        lst.cnt    = CNT_W'(1);
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (CNT_W'(i) == lst.cnt - CNT_W'(1)) begin
          lst.ent[i].eoc = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      held_r <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/upd_outq.sv =====
// result register: holds one beat's entries and drains them one per cycle while out_stall is low
module upd_outq
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  upd_list_t  lst,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_component,
  output upd_qstat_t stat
);

  logic [CNT_W-1:0]           cnt_r;
  upd_ent_t [MAX_RESULTS-1:0] ent_r;
  logic                       take;

  assign out_valid            = (cnt_r != '0);
  assign take                 = out_valid && !out_stall;
  assign out_byte             = ent_r[0].data;
  assign out_has_byte         = ent_r[0].has_byte;
  assign out_end_of_component = ent_r[0].eoc;

  assign stat.cnt      = cnt_r;
  assign stat.can_load = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= lst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= lst.ent;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

endmodule

// ===== tb/url_percent_decoder_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for url_percent_decoder: scoreboard and random flow control
module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 420;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eoc;
  } dec_res_t;

  class decode_board;
    dec_res_t   decoded_q[$];
    pend_t      esc_state;
    logic [7:0] held_digit;
    int         errors;

    function new();
      esc_state  = PEND_NONE;
      held_digit = 8'h00;
      errors     = 0;
    endfunction

    function bit hex_digit(logic [7:0] ch, output logic [3:0] v);
      logic [7:0] d;
      d = 8'h00;
      hex_digit = 1'b1;
      if (ch >= CH_0 && ch <= CH_9) begin
        d = ch - CH_0;
      end else if (ch >= CH_LA && ch <= CH_LF) begin
        d = ch - CH_LA + 8'd10;
      end else if (ch >= CH_UA && ch <= CH_UF) begin
        d = ch - CH_UA + 8'd10;
      end else begin
        hex_digit = 1'b0;
      end
      v = d[3:0];
    endfunction

    function void emit(logic [7:0] b, logic has);
      dec_res_t r;
      r.data = b;
      r.has  = has;
      r.eoc  = 1'b0;
      decoded_q = {decoded_q, r};
    endfunction

    function void plain_beat(logic [7:0] b, logic last);
      if (b == CH_PERCENT) begin
        if (!last) esc_state = PEND_PCT;
        else emit(CH_PERCENT, 1'b1);
      end else if (b == CH_PLUS) begin
        emit(CH_SPACE, 1'b1);
      end else begin
        emit(b, 1'b1);
      end
    endfunction

    function void note_beat(logic [7:0] b, logic last);
      int         before_n;
      logic [3:0] hi;
      logic [3:0] lo;
      dec_res_t   r;
      before_n = decoded_q.size();
      unique case (esc_state)
        PEND_PCT: begin
          if (hex_digit(b, lo) && !last) begin
            held_digit = b;
            esc_state  = PEND_HI;
            return;
          end
          emit(CH_PERCENT, 1'b1);
          esc_state = PEND_NONE;
          plain_beat(b, last);
        end
        PEND_HI: begin
          esc_state = PEND_NONE;
          if (hex_digit(b, lo)) begin
            void'(hex_digit(held_digit, hi));
            if ({hi, lo} != 8'h00) emit({hi, lo}, 1'b1);
          end else begin
            emit(CH_PERCENT, 1'b1);
            emit(held_digit, 1'b1);
            plain_beat(b, last);
          end
          held_digit = 8'h00;
        end
        default: begin
          esc_state = PEND_NONE;
          plain_beat(b, last);
        end
      endcase
      if (last) begin
        esc_state  = PEND_NONE;
        held_digit = 8'h00;
        if (decoded_q.size() == before_n) emit(8'h00, 1'b0);
        r = decoded_q.pop_back();
        r.eoc = 1'b1;
        decoded_q = {decoded_q, r};
      end
    endfunction

    function void check_beat(logic [7:0] b, logic has, logic eoc);
      dec_res_t e;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected beat byte %02h has %0b end %0b", $time, b, has, eoc);
        errors++;
        return;
      end
      e = decoded_q.pop_front();
      if (b !== e.data) begin
        $display("%0t: out_byte expected %02h got %02h", $time, e.data, b);
        errors++;
      end
      if (has !== e.has) begin
        $display("%0t: out_has_byte expected %0b got %0b", $time, e.has, has);
        errors++;
      end
      if (eoc !== e.eoc) begin
        $display("%0t: out_end_of_component expected %0b got %0b", $time, e.eoc, eoc);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_end_of_component;

  decode_board board = new();
  logic [7:0]  comp_q[$];
  int          items_sent = 0;
  int          burst_left = 0;
  int          cycles = 0;
  int          stall_mode = 0;

  url_percent_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_has_byte(out_has_byte),
    .out_end_of_component(out_end_of_component)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall pattern switches among four randomly chosen modes
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_beat(out_byte, out_has_byte, out_end_of_component);
    end
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= (cycles % 4 == 3);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_beat(b, last);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_comp();
    for (int i = 0; i < comp_q.size(); i++) begin
      send_beat(comp_q[i], i == comp_q.size() - 1);
    end
    comp_q.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    comp_q = {comp_q, b};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 10) return CH_0 + v;
    if ($urandom_range(0, 1)) return CH_LA + v - 8'd10;
    return CH_UA + v - 8'd10;
  endfunction

  initial begin
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decoded zero at end, short escape at end, lone percent, bad digits
    push_text("%00");
    send_comp();
    push_text("%4");
    send_comp();
    push_text("%");
    send_comp();
    push_text("%g+");
    send_comp();
    push_text("%%7e");
    send_comp();
    push_text("%F%2b");
    send_comp();
    // byte extremes, 0xff decode, zero decode in the middle, high byte pass-through
    add_byte(8'h00);
    push_text("%Ff%00");
    add_byte(8'h80);
    add_byte(8'hFF);
    send_comp();

    while (items_sent < RANDOM_ITEMS) begin
      len = $urandom_range(1, 12);
      while (comp_q.size() < len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            add_byte(CH_PERCENT);
            add_byte(rand_hex());
            add_byte(rand_hex());
          end
          4: push_text($urandom_range(0, 1) ? "%00" : "%0");
          5: add_byte(8'($urandom_range(0, 255)));
          6: add_byte(CH_PLUS);
          7: add_byte(CH_PERCENT);
          8: add_byte(rand_hex());
          default: begin
            add_byte(CH_PERCENT);
            add_byte(rand_hex());
            add_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
      send_comp();
    end

    in_valid <= 1'b0;
    while (board.decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.decoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/upd_pkg.sv
rtl/upd_decode.sv
rtl/upd_outq.sv
rtl/url_percent_decoder.sv
tb/url_percent_decoder_tb.sv
